// ----- sv/sidec_pkg.sv -----
// Shared types and constants for the signed integer to decimal ASCII converter.
// Depends on nothing; every other file of the block imports it.
package sidec_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned MAG_W   = 32;
    localparam int unsigned WIDE_W  = 34;
    localparam int unsigned NUM_POS = 10;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned DIGIT_W = 4;

    localparam logic [POS_W-1:0]  FIRST_POS  = 4'd9;
    localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd48;
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'd45;

    // Powers of ten, one per decimal position; the widest multiple needs 34 bits.
    localparam logic [WIDE_W-1:0] POW10 [NUM_POS] = '{
        34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
        34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000
    };

    typedef struct packed {
        logic load;
        logic emit_sign;
        logic emit_digit;
        logic skip;
    } cmd_t;

    typedef struct packed {
        logic neg;
        logic digit_zero;
        logic pos_zero;
        logic started;
        logic out_free;
    } status_t;

endpackage

// ----- sv/sidec_ifs.sv -----
// Valid/ready channel interfaces for the converter's input and output sides.
// Depends on sidec_pkg for the field widths.
interface sidec_in_if;
    import sidec_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sidec_out_if;
    import sidec_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  character;
    logic               last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

// ----- sv/sidec_ctrl.sv -----
// Controller state machine: sequences sign and digit positions of one conversion.
// Depends on sidec_pkg for the command and status structs.
module sidec_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sidec_pkg::status_t  status,
    output sidec_pkg::cmd_t     cmd
);
    import sidec_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SIGN  = 2'd1;
    localparam logic [1:0] ST_DIGIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                // A value that is not negative passes straight on to the digits.
                if (!status.neg)
                begin
                    state_next = ST_DIGIT;
                end
                else if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                // Leading zeros are dropped without using the output.
                if (status.digit_zero && !status.started && !status.pos_zero)
                begin
                    cmd.skip = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.pos_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/sidec_dp.sv -----
// Datapath: magnitude register, one decimal digit per cycle unless the output stalls, and the output register.
// Depends on sidec_pkg for the power-of-ten table and the command and status structs.
module sidec_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic signed [sidec_pkg::VALUE_W-1:0]  value,
    input  sidec_pkg::cmd_t                       cmd,
    output sidec_pkg::status_t                    status,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [sidec_pkg::CHAR_W-1:0]          character,
    output logic                                  last_char
);
    import sidec_pkg::*;

    logic [MAG_W-1:0]   mag_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               started_reg;
    logic               neg_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;

    logic [WIDE_W-1:0]  prod [NUM_POS];
    logic [WIDE_W-1:0]  mag_wide;
    logic [DIGIT_W-1:0] digit;
    logic [WIDE_W-1:0]  sub;
    logic               out_free;

    // The digit at the current position is the largest k with k * 10^pos <= magnitude.
    always_comb
    begin
        mag_wide = {2'b00, mag_reg};
        digit    = '0;
        prod[0]  = '0;
        for (int k = 1; k < NUM_POS; k++)
        begin
            prod[k] = WIDE_W'(POW10[pos_reg] * WIDE_W'(k));
        end
        for (int k = 1; k < NUM_POS; k++)
        begin
            if (mag_wide >= prod[k])
            begin
                digit = DIGIT_W'(k);
            end
        end
        sub = prod[digit];
    end

    assign out_free = !out_valid_reg || out_ready;

    assign status.neg        = neg_reg;
    assign status.digit_zero = (digit == '0);
    assign status.pos_zero   = (pos_reg == '0);
    assign status.started    = started_reg;
    assign status.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last_char = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_sign || cmd.emit_digit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg     <= value[VALUE_W-1];
            mag_reg     <= value[VALUE_W-1] ? (~value) + 1'b1 : value;
            pos_reg     <= FIRST_POS;
            started_reg <= 1'b0;
        end
        else if (cmd.skip || cmd.emit_digit)
        begin
            mag_reg     <= mag_reg - sub[MAG_W-1:0];
            pos_reg     <= pos_reg - 1'b1;
            started_reg <= started_reg | cmd.emit_digit;
        end

        if (cmd.emit_sign)
        begin
            char_reg <= MINUS_CHAR;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= DIGIT_BASE + {{(CHAR_W-DIGIT_W){1'b0}}, digit};
            last_reg <= (pos_reg == '0);
        end
    end

endmodule

// ----- sv/signed_int_to_decimal_ascii.sv -----
// Signed 32-bit integer to decimal ASCII text. Each input transfer carries one two's
// complement value; the block answers with its decimal text, one character per output
// transfer, most significant first, with last_char high on the final character. A
// negative value opens with '-', there are never leading zeros, zero gives a single '0',
// and the most negative value gives -2147483648. After a value is taken the block passes
// through the sign step (emitting '-' if needed, and nothing for a value that is not
// negative), then walks the ten decimal positions from 10^9 down to 10^0 at one position
// per cycle unless the output holds it back; a leading zero position still takes its
// step but produces nothing. The sign and each emitted digit wait while the output
// register holds a character not yet taken. The input is ready only between conversions,
// but the last character may still sit in the output register while the next value is
// taken. There is no configuration and no state kept between values.
// Depends on sidec_pkg, sidec_ifs, sidec_ctrl and sidec_dp.
module signed_int_to_decimal_ascii (
    input  logic        clk,
    input  logic        rst_n,
    sidec_in_if.sink    din,
    sidec_out_if.source dout
);
    import sidec_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    // The controller decides, per cycle, whether to take a value, emit the sign,
    // emit a digit or drop a leading zero.
    sidec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the magnitude and position and owns the output register.
    sidec_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (din.value),
        .cmd       (cmd),
        .status    (status),
        .out_ready (dout.ready),
        .out_valid (dout.valid),
        .character (dout.character),
        .last_char (dout.last_char)
    );

    assign din.ready = in_ready;

    // Only one action is commanded in any cycle.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.emit_sign, cmd.emit_digit, cmd.skip}))
        else $error("more than one datapath command in a cycle");

    // A conversion keeps the input closed on the cycle after it starts.
    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        din.valid && din.ready |=> !din.ready)
        else $error("input reopened straight after a transfer");

    // Every character shown is a minus sign or a decimal digit.
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> (dout.character == MINUS_CHAR ||
                        (dout.character >= DIGIT_BASE && dout.character <= DIGIT_BASE + 8'd9)))
        else $error("character outside the sign and digit codes");

    // The minus sign is never the final character of a text.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && dout.character == MINUS_CHAR |-> !dout.last_char)
        else $error("minus sign flagged as the final character");

endmodule
